// ----- hdl/glw_pkg.sv -----
`default_nettype none
package glw_pkg;

  // default geometry
  localparam int DEF_CHIP_COLUMNS  = 60;
  localparam int DEF_CELLS_PER_ROW = 20;
  localparam int DEF_TEXT_ROWS     = 4;
  localparam int DEF_GLYPH_WIDTH   = 5;

  // widths that cover every legal geometry
  localparam int COL_W  = 5;   // cursor cell column
  localparam int ROW_W  = 3;   // cursor row, up to eight pages
  localparam int PIX_W  = 9;   // pixel column of a cell, up to 511
  localparam int Q_W    = 4;   // glyph column counter, 0..GLYPH_WIDTH
  localparam int CNT_W  = 4;   // bus transfers emitted for one item

  localparam int MAX_RESULTS = 9;
  localparam int FONT_COLS   = 5;
  localparam int GLYPH_W     = FONT_COLS * 8;

  localparam logic [7:0] FONT_FIRST = 8'h20;
  localparam logic [7:0] PAGE_CMD   = 8'hB8;

  // operation codes on the input stream
  localparam logic OP_WRITE_CHAR = 1'b0;
  localparam logic OP_SET_CURSOR = 1'b1;

  // bus cycle kind
  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_CHIP1 = 2'd1,
    KIND_CHIP2 = 2'd2
  } bus_kind_t;

  // back-end sequencer phase
  typedef enum logic [1:0] {
    PH_COL  = 2'd0,
    PH_PAGE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // one classified item, handed from the front to the back
  typedef struct packed {
    logic                 set_cursor;
    logic [PIX_W-1:0]     pix;
    logic [ROW_W-1:0]     row;
    logic [GLYPH_W-1:0]   glyph;   // first column in the top byte
  } job_t;

  // 5x7 font, characters 0x20..0x7f, leftmost column in the top byte
  function automatic logic [GLYPH_W-1:0] font_cols(input logic [6:0] idx);
    logic [GLYPH_W-1:0] g;
    case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00005f0000;
      7'd2:  g = 40'h0003000300;
      7'd3:  g = 40'h147f147f14;
      7'd4:  g = 40'h242a7f2a12;
      7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001c224100;
      7'd9:  g = 40'h0041221c00;
      7'd10: g = 40'h14083e0814;
      7'd11: g = 40'h08083e0808;
      7'd12: g = 40'h0050300000;
      7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3e5149453e;
      7'd17: g = 40'h00427f4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454b31;
      7'd20: g = 40'h1814127f10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3c4a494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291e;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0814224100;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413e;
      7'd33: g = 40'h7e1111117e;
      7'd34: g = 40'h7f49494936;
      7'd35: g = 40'h3e41414122;
      7'd36: g = 40'h7f4141221c;
      7'd37: g = 40'h7f49494941;
      7'd38: g = 40'h7f09090901;
      7'd39: g = 40'h3e4149497a;
      7'd40: g = 40'h7f0808087f;
      7'd41: g = 40'h00417f4100;
      7'd42: g = 40'h2040413f01;
      7'd43: g = 40'h7f08142241;
      7'd44: g = 40'h7f40404040;
      7'd45: g = 40'h7f020c027f;
      7'd46: g = 40'h7f0408107f;
      7'd47: g = 40'h3e4141413e;
      7'd48: g = 40'h7f09090906;
      7'd49: g = 40'h3e4151215e;
      7'd50: g = 40'h7f09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017f0101;
      7'd53: g = 40'h3f4040403f;
      7'd54: g = 40'h1f2040201f;
      7'd55: g = 40'h3f4038403f;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007f414100;
      7'd60: g = 40'h0204081020;
      7'd61: g = 40'h0041417f00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7f48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487f;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087e090102;
      7'd71: g = 40'h0c5252523e;
      7'd72: g = 40'h7f08040478;
      7'd73: g = 40'h00447d4000;
      7'd74: g = 40'h2040443d00;
      7'd75: g = 40'h7f10284400;
      7'd76: g = 40'h00417f4000;
      7'd77: g = 40'h7c04180478;
      7'd78: g = 40'h7c08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7c14141408;
      7'd81: g = 40'h081414187c;
      7'd82: g = 40'h7c08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043f444020;
      7'd85: g = 40'h3c4040207c;
      7'd86: g = 40'h1c2040201c;
      7'd87: g = 40'h3c4030403c;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0c5050503c;
      7'd90: g = 40'h4464544c44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007f0000;
      7'd93: g = 40'h0041360800;
      7'd94: g = 40'h1008081008;
      7'd95: g = 40'h0000020502;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/glw_front.sv -----
`default_nettype none
module glw_front #(
  parameter int CELLS_PER_ROW = glw_pkg::DEF_CELLS_PER_ROW,
  parameter int TEXT_ROWS     = glw_pkg::DEF_TEXT_ROWS,
  parameter int GLYPH_WIDTH   = glw_pkg::DEF_GLYPH_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       operation,
  input  wire logic [7:0]                 char_code,
  input  wire logic [glw_pkg::COL_W-1:0]  new_col,
  input  wire logic [1:0]                 new_row,
  input  wire logic                       full,
  output logic                            push,
  output glw_pkg::job_t                   job
);
  import glw_pkg::*;

  logic [COL_W-1:0] cursor_x, cursor_x_next;
  logic [ROW_W-1:0] cursor_y, cursor_y_next;
  logic [COL_W-1:0] cx;
  logic [ROW_W-1:0] cy;
  logic [ROW_W-1:0] row_in;
  logic             in_font;
  logic [7:0]       font_off;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  // clamp the requested cursor, or take the stored one
  always_comb begin
    row_in = ROW_W'(new_row);
    if (operation == OP_SET_CURSOR) begin
      cx = (new_col > COL_W'(CELLS_PER_ROW - 1)) ? COL_W'(CELLS_PER_ROW - 1) : new_col;
      cy = (row_in > ROW_W'(TEXT_ROWS - 1)) ? ROW_W'(TEXT_ROWS - 1) : row_in;
    end else begin
      cx = cursor_x;
      cy = cursor_y;
    end
  end

  // cursor after this item
  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    if (push) begin
      if (operation == OP_SET_CURSOR) begin
        cursor_x_next = cx;
        cursor_y_next = cy;
      end else if (cursor_x == COL_W'(CELLS_PER_ROW - 1)) begin
        cursor_x_next = '0;
        cursor_y_next = (cursor_y == ROW_W'(TEXT_ROWS - 1)) ? '0 : cursor_y + 1'b1;
      end else begin
        cursor_x_next = cursor_x + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

  // classify: cell pixel column, page and glyph columns
  assign in_font  = !char_code[7] && (char_code[6:5] != 2'b00);
  assign font_off = char_code - FONT_FIRST;

  always_comb begin
    job.set_cursor = (operation == OP_SET_CURSOR);
    job.pix        = PIX_W'(cx) * PIX_W'(GLYPH_WIDTH + 1);
    job.row        = cy;
    job.glyph      = in_font ? font_cols(font_off[6:0]) : '0;
  end

endmodule
`default_nettype wire

// ----- hdl/glw_queue.sv -----
`default_nettype none
module glw_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire glw_pkg::job_t  push_job,
  output logic                full,
  input  wire logic           pop,
  output glw_pkg::job_t       head,
  output logic                empty
);
  import glw_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  // two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/glw_back.sv -----
`default_nettype none
module glw_back #(
  parameter int CHIP_COLUMNS = glw_pkg::DEF_CHIP_COLUMNS,
  parameter int GLYPH_WIDTH  = glw_pkg::DEF_GLYPH_WIDTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire glw_pkg::job_t  head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output glw_pkg::bus_kind_t  out_kind,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import glw_pkg::*;

  phase_t           phase, phase_next;
  logic [Q_W-1:0]   q, q_next;
  logic [PIX_W-1:0] pix_cur, pix_cur_next;
  logic             bound_done, bound_done_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic             emit;
  logic             fin;
  bus_kind_t        kind;
  logic [7:0]       bval;
  logic [PIX_W-1:0] col_cmd;
  logic             at_bound;
  logic             cap_hit;

  // pick one glyph column, blank past the font width
  function automatic logic [7:0] glyph_col(input logic [GLYPH_W-1:0] g,
                                           input logic [Q_W-1:0] qi);
    logic [7:0] b;
    case (qi)
      4'd0:    b = g[39:32];
      4'd1:    b = g[31:24];
      4'd2:    b = g[23:16];
      4'd3:    b = g[15:8];
      4'd4:    b = g[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign emit     = !empty && (!out_valid || out_ready);
  assign col_cmd  = (head.pix > PIX_W'(CHIP_COLUMNS)) ? head.pix - PIX_W'(CHIP_COLUMNS)
                                                       : head.pix;
  assign at_bound = (pix_cur == PIX_W'(CHIP_COLUMNS)) && !bound_done;
  assign cap_hit  = (cnt == CNT_W'(MAX_RESULTS - 1));

  // next bus transfer of the job at the queue head
  always_comb begin
    kind            = KIND_CMD;
    bval            = 8'h00;
    fin             = 1'b0;
    phase_next      = phase;
    q_next          = q;
    pix_cur_next    = pix_cur;
    bound_done_next = bound_done;
    cnt_next        = cnt;
    case (phase)
      PH_COL: begin
        bval       = col_cmd[7:0];
        fin        = cap_hit;
        phase_next = PH_PAGE;
      end
      PH_PAGE: begin
        bval         = PAGE_CMD | {5'b00000, head.row};
        fin          = head.set_cursor || cap_hit;
        phase_next   = PH_DATA;
        q_next       = '0;
        pix_cur_next = head.pix;
      end
      PH_DATA: begin
        if (at_bound) begin
          // column 0 to both chips before crossing into chip two
          bval            = 8'h00;
          fin             = cap_hit;
          bound_done_next = 1'b1;
        end else begin
          kind         = (pix_cur < PIX_W'(CHIP_COLUMNS)) ? KIND_CHIP1 : KIND_CHIP2;
          bval         = (q < Q_W'(GLYPH_WIDTH)) ? glyph_col(head.glyph, q) : 8'h00;
          fin          = (q == Q_W'(GLYPH_WIDTH)) || cap_hit;
          q_next       = q + 1'b1;
          pix_cur_next = pix_cur + 1'b1;
        end
      end
      default: begin
        phase_next = PH_COL;
      end
    endcase
    if (emit) begin
      cnt_next = cnt + 1'b1;
      if (fin) begin
        phase_next      = PH_COL;
        bound_done_next = 1'b0;
        cnt_next        = '0;
      end
    end else begin
      phase_next      = phase;
      q_next          = q;
      pix_cur_next    = pix_cur;
      bound_done_next = bound_done;
      cnt_next        = cnt;
    end
  end

  assign pop = emit && fin;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_COL;
      bound_done <= 1'b0;
      cnt        <= '0;
    end else begin
      phase      <= phase_next;
      bound_done <= bound_done_next;
      cnt        <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q       <= q_next;
    pix_cur <= pix_cur_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= kind;
      out_byte <= bval;
      out_last <= fin;
    end
  end

  // checks on the sequencer
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RESULTS - 1))
    else $error("transfer count past the per-item cap");

  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_COL) |-> !empty)
    else $error("job in progress without a queue entry");

  a_bound_phase: assert property (@(posedge clk) disable iff (rst)
    bound_done |-> (phase == PH_DATA))
    else $error("chip boundary flag outside data phase");

  a_q_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (q <= Q_W'(GLYPH_WIDTH)))
    else $error("glyph column counter overran");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && out_last))
    else $error("job retired without a last transfer");

endmodule
`default_nettype wire

// ----- hdl/text_lcd_glyph_writer.sv -----
`default_nettype none
// Text console for a two-controller graphic LCD. Each input transfer either
// sets the cursor (two command transfers out: column, page) or draws one
// character cell at the cursor (column and page commands, the glyph columns
// and one blank column, plus a column-0 command where a cell crosses into
// the second chip: 8 or 9 transfers with the default geometry, at most 9).
// The back-end sequencer puts out one bus transfer per clock when the output
// is taken. The front end classifies and looks up the glyph combinationally,
// and a two-entry queue lets it take new items while the back end is still
// busy.
module text_lcd_glyph_writer #(
  parameter int CHIP_COLUMNS  = glw_pkg::DEF_CHIP_COLUMNS,
  parameter int CELLS_PER_ROW = glw_pkg::DEF_CELLS_PER_ROW,
  parameter int TEXT_ROWS     = glw_pkg::DEF_TEXT_ROWS,
  parameter int GLYPH_WIDTH   = glw_pkg::DEF_GLYPH_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // char_code[7:0], new_col[12:8], new_row[14:13]
  input  wire logic [0:0]  s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // bus_byte
  output logic [1:0]       m_axis_tuser,   // bus_kind
  output logic             m_axis_tlast    // last
);
  import glw_pkg::*;

  job_t      fe_job;
  job_t      q_head;
  logic      fe_push;
  logic      q_full;
  logic      q_empty;
  logic      be_pop;
  bus_kind_t be_kind;

  // front end: cursor, classification, glyph lookup
  glw_front #(
    .CELLS_PER_ROW (CELLS_PER_ROW),
    .TEXT_ROWS     (TEXT_ROWS),
    .GLYPH_WIDTH   (GLYPH_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .operation (s_axis_tuser[0]),
    .char_code (s_axis_tdata[7:0]),
    .new_col   (s_axis_tdata[12:8]),
    .new_row   (s_axis_tdata[14:13]),
    .full      (q_full),
    .push      (fe_push),
    .job       (fe_job)
  );

  // job queue
  glw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fe_push),
    .push_job (fe_job),
    .full     (q_full),
    .pop      (be_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // back end: bus transfer sequencer
  glw_back #(
    .CHIP_COLUMNS (CHIP_COLUMNS),
    .GLYPH_WIDTH  (GLYPH_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (be_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (be_kind),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tuser = be_kind;

endmodule
`default_nettype wire

// ----- test/tb_text_lcd_glyph_writer.sv -----
`timescale 1ns / 100ps

module tb_text_lcd_glyph_writer;
  import glw_pkg::*;

  localparam int CHIP_COLS   = DEF_CHIP_COLUMNS;
  localparam int CELLS       = DEF_CELLS_PER_ROW;
  localparam int ROWS        = DEF_TEXT_ROWS;
  localparam int GLYPH_COLS  = DEF_GLYPH_WIDTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] FONT_LAST_CODE = 8'h7F;

  // 5x7 font, five column bytes per character from 0x20 up, leftmost column first
  localparam logic [7:0] FONT_BYTES [0:479] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h5f,8'h00,8'h00,
    8'h00,8'h03,8'h00,8'h03,8'h00,8'h14,8'h7f,8'h14,8'h7f,8'h14,
    8'h24,8'h2a,8'h7f,8'h2a,8'h12,8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50,8'h00,8'h05,8'h03,8'h00,8'h00,
    8'h00,8'h1c,8'h22,8'h41,8'h00,8'h00,8'h41,8'h22,8'h1c,8'h00,
    8'h14,8'h08,8'h3e,8'h08,8'h14,8'h08,8'h08,8'h3e,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h60,8'h60,8'h00,8'h00,8'h20,8'h10,8'h08,8'h04,8'h02,
    8'h3e,8'h51,8'h49,8'h45,8'h3e,8'h00,8'h42,8'h7f,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46,8'h21,8'h41,8'h45,8'h4b,8'h31,
    8'h18,8'h14,8'h12,8'h7f,8'h10,8'h27,8'h45,8'h45,8'h45,8'h39,
    8'h3c,8'h4a,8'h49,8'h49,8'h30,8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36,8'h06,8'h49,8'h49,8'h29,8'h1e,
    8'h00,8'h36,8'h36,8'h00,8'h00,8'h00,8'h56,8'h36,8'h00,8'h00,
    8'h08,8'h14,8'h22,8'h41,8'h00,8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h00,8'h41,8'h22,8'h14,8'h08,8'h02,8'h01,8'h51,8'h09,8'h06,
    8'h32,8'h49,8'h79,8'h41,8'h3e,8'h7e,8'h11,8'h11,8'h11,8'h7e,
    8'h7f,8'h49,8'h49,8'h49,8'h36,8'h3e,8'h41,8'h41,8'h41,8'h22,
    8'h7f,8'h41,8'h41,8'h22,8'h1c,8'h7f,8'h49,8'h49,8'h49,8'h41,
    8'h7f,8'h09,8'h09,8'h09,8'h01,8'h3e,8'h41,8'h49,8'h49,8'h7a,
    8'h7f,8'h08,8'h08,8'h08,8'h7f,8'h00,8'h41,8'h7f,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3f,8'h01,8'h7f,8'h08,8'h14,8'h22,8'h41,
    8'h7f,8'h40,8'h40,8'h40,8'h40,8'h7f,8'h02,8'h0c,8'h02,8'h7f,
    8'h7f,8'h04,8'h08,8'h10,8'h7f,8'h3e,8'h41,8'h41,8'h41,8'h3e,
    8'h7f,8'h09,8'h09,8'h09,8'h06,8'h3e,8'h41,8'h51,8'h21,8'h5e,
    8'h7f,8'h09,8'h19,8'h29,8'h46,8'h46,8'h49,8'h49,8'h49,8'h31,
    8'h01,8'h01,8'h7f,8'h01,8'h01,8'h3f,8'h40,8'h40,8'h40,8'h3f,
    8'h1f,8'h20,8'h40,8'h20,8'h1f,8'h3f,8'h40,8'h38,8'h40,8'h3f,
    8'h63,8'h14,8'h08,8'h14,8'h63,8'h07,8'h08,8'h70,8'h08,8'h07,
    8'h61,8'h51,8'h49,8'h45,8'h43,8'h00,8'h7f,8'h41,8'h41,8'h00,
    8'h02,8'h04,8'h08,8'h10,8'h20,8'h00,8'h41,8'h41,8'h7f,8'h00,
    8'h04,8'h02,8'h01,8'h02,8'h04,8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h00,8'h01,8'h02,8'h04,8'h00,8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7f,8'h48,8'h44,8'h44,8'h38,8'h38,8'h44,8'h44,8'h44,8'h20,
    8'h38,8'h44,8'h44,8'h48,8'h7f,8'h38,8'h54,8'h54,8'h54,8'h18,
    8'h08,8'h7e,8'h09,8'h01,8'h02,8'h0c,8'h52,8'h52,8'h52,8'h3e,
    8'h7f,8'h08,8'h04,8'h04,8'h78,8'h00,8'h44,8'h7d,8'h40,8'h00,
    8'h20,8'h40,8'h44,8'h3d,8'h00,8'h7f,8'h10,8'h28,8'h44,8'h00,
    8'h00,8'h41,8'h7f,8'h40,8'h00,8'h7c,8'h04,8'h18,8'h04,8'h78,
    8'h7c,8'h08,8'h04,8'h04,8'h78,8'h38,8'h44,8'h44,8'h44,8'h38,
    8'h7c,8'h14,8'h14,8'h14,8'h08,8'h08,8'h14,8'h14,8'h18,8'h7c,
    8'h7c,8'h08,8'h04,8'h04,8'h08,8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3f,8'h44,8'h40,8'h20,8'h3c,8'h40,8'h40,8'h20,8'h7c,
    8'h1c,8'h20,8'h40,8'h20,8'h1c,8'h3c,8'h40,8'h30,8'h40,8'h3c,
    8'h44,8'h28,8'h10,8'h28,8'h44,8'h0c,8'h50,8'h50,8'h50,8'h3c,
    8'h44,8'h64,8'h54,8'h4c,8'h44,8'h00,8'h08,8'h36,8'h41,8'h00,
    8'h00,8'h00,8'h7f,8'h00,8'h00,8'h00,8'h41,8'h36,8'h08,8'h00,
    8'h10,8'h08,8'h08,8'h10,8'h08,8'h00,8'h00,8'h02,8'h05,8'h02
  };

  // one expected bus transfer
  typedef struct packed {
    bus_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } bus_xfer_t;

  // cursor tracking, expected bus transfers and their comparison
  class lcd_bus_scoreboard;
    bus_xfer_t  bus_q[$];
    logic [4:0] cur_col;
    logic [1:0] cur_row;
    int errors, chars_drawn, cursor_moves, xfers_checked, boundary_hits;

    function new();
      cur_col = '0;
      cur_row = '0;
    endfunction

    function int pending();
      return bus_q.size();
    endfunction

    function void push_xfer(bus_kind_t kind, logic [7:0] data);
      bus_xfer_t x;
      x.kind = kind;
      x.data = data;
      x.last = 1'b0;
      bus_q.push_back(x);
    endfunction

    function logic [7:0] glyph_column(logic [7:0] code, int q);
      if (code < FONT_FIRST || code > FONT_LAST_CODE || q >= 5) return 8'h00;
      return FONT_BYTES[(int'(code) - int'(FONT_FIRST)) * 5 + q];
    endfunction

    // column and page commands for the current cell, gives its first pixel column
    function int unsigned position_cmds();
      int unsigned pix;
      int unsigned col_cmd;
      pix = cur_col * (GLYPH_COLS + 1);
      col_cmd = (pix > CHIP_COLS) ? pix - CHIP_COLS : pix;
      push_xfer(KIND_CMD, 8'(col_cmd));
      push_xfer(KIND_CMD, PAGE_CMD | {6'd0, cur_row});
      return pix;
    endfunction

    function void note_item(logic op, logic [7:0] code, logic [4:0] col, logic [1:0] row);
      int unsigned pix;
      logic [7:0] col_byte;
      if (op == OP_SET_CURSOR) begin
        cur_col = (col > CELLS - 1) ? 5'(CELLS - 1) : col;
        cur_row = (row > ROWS - 1) ? 2'(ROWS - 1) : row;
        void'(position_cmds());
        cursor_moves++;
      end else begin
        pix = position_cmds();
        // glyph columns then one blank column
        for (int q = 0; q <= GLYPH_COLS; q++) begin
          col_byte = (q < GLYPH_COLS) ? glyph_column(code, q) : 8'h00;
          if (pix == CHIP_COLS) begin
            push_xfer(KIND_CMD, 8'h00);
            boundary_hits++;
          end
          push_xfer((pix < CHIP_COLS) ? KIND_CHIP1 : KIND_CHIP2, col_byte);
          pix++;
        end
        // advance with wrap
        if (int'(cur_col) + 1 >= CELLS) begin
          cur_col = '0;
          cur_row = (int'(cur_row) + 1 >= ROWS) ? 2'd0 : cur_row + 2'd1;
        end else begin
          cur_col = cur_col + 5'd1;
        end
        chars_drawn++;
      end
      bus_q[bus_q.size() - 1].last = 1'b1;
    endfunction

    function void check_transfer(logic [1:0] kind, logic [7:0] data, logic last);
      bus_xfer_t x;
      if (bus_q.size() == 0) begin
        $display("%0t: unexpected transfer kind %0d byte %h last %b", $time, kind, data, last);
        errors++;
        return;
      end
      x = bus_q.pop_front();
      xfers_checked++;
      if (x.kind !== kind) begin
        $display("%0t: bus kind expected %0d got %0d", $time, x.kind, kind);
        errors++;
      end
      if (x.data !== data) begin
        $display("%0t: bus byte expected %h got %h", $time, x.data, data);
        errors++;
      end
      if (x.last !== last) begin
        $display("%0t: last expected %b got %b", $time, x.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int send_idle_pct = 27;
  int recv_idle_pct = 58;
  int cycle_count = 0;
  lcd_bus_scoreboard sb = new();

  text_lcd_glyph_writer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watch both streams on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[12:8],
                     s_axis_tdata[14:13]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_transfer(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transfers outstanding", cycle_count, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // one input transfer, entered and left at a falling edge
  task automatic send_item(input logic op, input logic [7:0] code,
                           input logic [4:0] col, input logic [1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, row, col, code};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender off until the bus has caught up
  task automatic wait_bus_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // mostly text runs with the odd cursor jump, a few codes outside the font
  task automatic send_random_text(input int count);
    logic       op;
    logic [7:0] code;
    logic [4:0] col;
    for (int i = 0; i < count; i++) begin
      op   = ($urandom_range(99) < 20) ? OP_SET_CURSOR : OP_WRITE_CHAR;
      code = ($urandom_range(99) < 80) ? 8'($urandom_range(32, 127)) : 8'($urandom_range(0, 255));
      col  = ($urandom_range(99) < 90) ? 5'($urandom_range(0, 19)) : 5'($urandom_range(20, 31));
      send_item(op, code, col, 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: font edges and codes outside the font, starting at the home cell
    send_item(OP_SET_CURSOR, 8'h00, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'h20, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'h7F, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'h00, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'h1F, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'h80, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'hFF, 5'd0, 2'd0);
    // last cell of chip one, then the cell that starts on the chip boundary
    send_item(OP_SET_CURSOR, 8'hFF, 5'd9, 2'd1);
    send_item(OP_WRITE_CHAR, 8'h41, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'h5A, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'h61, 5'd0, 2'd0);
    // column clamp and wrap from the bottom right corner back home
    send_item(OP_SET_CURSOR, 8'h00, 5'd31, 2'd3);
    send_item(OP_WRITE_CHAR, 8'h7E, 5'd0, 2'd0);
    send_item(OP_WRITE_CHAR, 8'h5A, 5'd0, 2'd0);
    // end of a row into the next one
    send_item(OP_SET_CURSOR, 8'h00, 5'd19, 2'd2);
    send_item(OP_WRITE_CHAR, 8'h55, 5'd0, 2'd0);
    send_item(OP_SET_CURSOR, 8'h00, 5'd20, 2'd0);
    send_item(OP_SET_CURSOR, 8'h00, 5'd10, 2'd3);
    send_item(OP_WRITE_CHAR, 8'h2A, 5'd0, 2'd0);
    send_item(OP_SET_CURSOR, 8'h00, 5'd16, 2'd2);
    send_item(OP_WRITE_CHAR, 8'h21, 5'd0, 2'd0);
    wait_bus_drained();

    // random text under three idling patterns
    send_random_text(110);
    wait_bus_drained();
    send_idle_pct = 58;
    recv_idle_pct = 27;
    send_random_text(110);
    wait_bus_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_text(110);

    wait_bus_drained();
    repeat (24) @(negedge clk);

    $display("drew %0d characters and made %0d cursor moves", sb.chars_drawn, sb.cursor_moves);
    $display("checked %0d bus transfers, %0d chip boundary crossings",
             sb.xfers_checked, sb.boundary_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
